// ===== sv/rot_pkg.sv =====
// ----------------------------------------------------------------------------
// rot_pkg: types and constants for the point rotation pipeline
// Transaction structs, CORDIC constants and the arctangent table in Q2.30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rot_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic [15:0]        angle_turns;
    } t_rot_in;

    typedef struct packed {
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic               overflow;
    } t_rot_out;

    localparam int CORDIC_STEPS = 30;

    // 1/gain of the 30-step rotation, Q2.30
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sh26DD3B6A;
    // pi/2 in Q2.30
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
    localparam logic signed [32:0] ONE_Q30 = 33'sh0_4000_0000;

    localparam logic signed [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
        32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
        32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
        32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
        32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
        32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F, 32'sh0000003F,
        32'sh0000001F, 32'sh0000000F, 32'sh00000008, 32'sh00000004, 32'sh00000002
    };

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

endpackage

// ===== sv/point_rotate_about_pivot.sv =====
// ----------------------------------------------------------------------------
// point_rotate_about_pivot: rotate a Q16.16 point about a pivot
// Takes one transaction per clock and returns each result in order, as a
// one-cycle o_result_valid strobe. busy stays low, so start may be held high
// every cycle. The datapath runs through one entry stage (offset and
// angle-to-radian multiply), 30 CORDIC stages of the fully unrolled
// sine/cosine unit, then quadrant fold, the four products, rounding, and pivot
// add with saturation, one register stage each. Results saturate to the
// signed 32-bit range and overflow flags either coordinate clamped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_rotate_about_pivot #(
    parameter int ANGLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rot_pkg::t_rot_in  i_item,
    output logic              o_result_valid,
    output rot_pkg::t_rot_out o_result
);

    import rot_pkg::*;

    // angle bits that actually reach the phase
    localparam int KEEP    = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int STEPS   = CORDIC_STEPS;
    localparam int LATENCY = STEPS + 5;

    localparam logic signed [65:0] ROUND_HALF = 66'sh2000_0000;
    localparam logic signed [36:0] SAT_MAX    = 37'sh0_7FFF_FFFF;
    localparam logic signed [36:0] SAT_MIN    = -37'sh0_8000_0000;

    // ------------------------------------------------------------------------
    // entry stage: offset from pivot, quadrant and theta
    // ------------------------------------------------------------------------
    logic [KEEP-1:0]  n_angle;
    logic [KEEP-3:0]  n_angle_lo;
    logic [KEEP+28:0] n_theta_prod;
    logic [STEPS:0]   r_cv;

    logic signed [31:0] r_x    [0:STEPS];
    logic signed [31:0] r_y    [0:STEPS];
    logic signed [31:0] r_z    [0:STEPS];
    logic [1:0]         r_quad [0:STEPS];
    logic signed [32:0] r_dx   [0:STEPS];
    logic signed [32:0] r_dy   [0:STEPS];
    logic signed [31:0] r_cx   [0:STEPS];
    logic signed [31:0] r_cy   [0:STEPS];

    assign busy = 1'b0;

    always_comb begin
        n_angle      = i_item.angle_turns[15 -: KEEP];
        n_angle_lo   = n_angle[KEEP-3:0];
        // r * pi/2 / 2^30 with r = angle_lo << (32 - KEEP)
        n_theta_prod = (KEEP+29)'(n_angle_lo) * (KEEP+29)'(HALF_PI_Q30);
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= INV_GAIN_Q30;
        r_y[0]    <= '0;
        r_z[0]    <= $signed({1'b0, n_theta_prod[KEEP+28:KEEP-2]});
        r_quad[0] <= n_angle[KEEP-1 -: 2];
        r_dx[0]   <= 33'(i_item.point_x) - 33'(i_item.pivot_x);
        r_dy[0]   <= 33'(i_item.point_y) - 33'(i_item.pivot_y);
        r_cx[0]   <= i_item.pivot_x;
        r_cy[0]   <= i_item.pivot_y;
    end

    // valid bits for the entry stage and CORDIC stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else begin
            r_cv <= {r_cv[STEPS-1:0], start & ~busy};
        end
    end

    // ------------------------------------------------------------------------
    // CORDIC, one micro-rotation per stage
    // ------------------------------------------------------------------------
    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        logic signed [31:0] n_x;
        logic signed [31:0] n_y;
        logic signed [31:0] n_z;

        always_comb begin
            if (!r_z[k][31]) begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_z = r_z[k] - ATAN_Q30[k];
            end else begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_z = r_z[k] + ATAN_Q30[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k+1]    <= n_x;
            r_y[k+1]    <= n_y;
            r_z[k+1]    <= n_z;
            r_quad[k+1] <= r_quad[k];
            r_dx[k+1]   <= r_dx[k];
            r_dy[k+1]   <= r_dy[k];
            r_cx[k+1]   <= r_cx[k];
            r_cy[k+1]   <= r_cy[k];
        end
    end

    // ------------------------------------------------------------------------
    // quadrant fold and unit clamp
    // ------------------------------------------------------------------------
    logic signed [32:0] n_xe;
    logic signed [32:0] n_ye;
    logic signed [32:0] n_cos;
    logic signed [32:0] n_sin;
    logic signed [32:0] n_cos_cl;
    logic signed [32:0] n_sin_cl;

    always_comb begin
        n_xe = 33'(r_x[STEPS]);
        n_ye = 33'(r_y[STEPS]);
        case (r_quad[STEPS])
            QUAD_I: begin
                n_cos = n_xe;
                n_sin = n_ye;
            end
            QUAD_II: begin
                n_cos = -n_ye;
                n_sin = n_xe;
            end
            QUAD_III: begin
                n_cos = -n_xe;
                n_sin = -n_ye;
            end
            default: begin
                n_cos = n_ye;
                n_sin = -n_xe;
            end
        endcase

        if (n_cos > ONE_Q30) begin
            n_cos_cl = ONE_Q30;
        end else if (n_cos < -ONE_Q30) begin
            n_cos_cl = -ONE_Q30;
        end else begin
            n_cos_cl = n_cos;
        end

        if (n_sin > ONE_Q30) begin
            n_sin_cl = ONE_Q30;
        end else if (n_sin < -ONE_Q30) begin
            n_sin_cl = -ONE_Q30;
        end else begin
            n_sin_cl = n_sin;
        end
    end

    logic               r_f_v;
    logic signed [31:0] r_f_cos;
    logic signed [31:0] r_f_sin;
    logic signed [32:0] r_f_dx;
    logic signed [32:0] r_f_dy;
    logic signed [31:0] r_f_cx;
    logic signed [31:0] r_f_cy;

    always_ff @(posedge i_clk) begin
        r_f_cos <= n_cos_cl[31:0];
        r_f_sin <= n_sin_cl[31:0];
        r_f_dx  <= r_dx[STEPS];
        r_f_dy  <= r_dy[STEPS];
        r_f_cx  <= r_cx[STEPS];
        r_f_cy  <= r_cy[STEPS];
    end

    // ------------------------------------------------------------------------
    // products
    // ------------------------------------------------------------------------
    logic               r_p_v;
    logic signed [64:0] r_p_xc;
    logic signed [64:0] r_p_ys;
    logic signed [64:0] r_p_xs;
    logic signed [64:0] r_p_yc;
    logic signed [31:0] r_p_cx;
    logic signed [31:0] r_p_cy;

    always_ff @(posedge i_clk) begin
        r_p_xc <= 65'(r_f_dx) * 65'(r_f_cos);
        r_p_ys <= 65'(r_f_dy) * 65'(r_f_sin);
        r_p_xs <= 65'(r_f_dx) * 65'(r_f_sin);
        r_p_yc <= 65'(r_f_dy) * 65'(r_f_cos);
        r_p_cx <= r_f_cx;
        r_p_cy <= r_f_cy;
    end

    // ------------------------------------------------------------------------
    // sum and round half up to Q16.16
    // ------------------------------------------------------------------------
    logic signed [65:0] n_sum_x;
    logic signed [65:0] n_sum_y;

    always_comb begin
        n_sum_x = 66'(r_p_xc) - 66'(r_p_ys) + ROUND_HALF;
        n_sum_y = 66'(r_p_xs) + 66'(r_p_yc) + ROUND_HALF;
    end

    logic               r_r_v;
    logic signed [35:0] r_r_x;
    logic signed [35:0] r_r_y;
    logic signed [31:0] r_r_cx;
    logic signed [31:0] r_r_cy;

    always_ff @(posedge i_clk) begin
        r_r_x  <= n_sum_x[65:30];
        r_r_y  <= n_sum_y[65:30];
        r_r_cx <= r_p_cx;
        r_r_cy <= r_p_cy;
    end

    // ------------------------------------------------------------------------
    // pivot add back and saturation
    // ------------------------------------------------------------------------
    logic signed [36:0] n_fx;
    logic signed [36:0] n_fy;
    logic signed [31:0] n_sx;
    logic signed [31:0] n_sy;
    logic               n_ovx;
    logic               n_ovy;

    always_comb begin
        n_fx  = 37'(r_r_x) + 37'(r_r_cx);
        n_fy  = 37'(r_r_y) + 37'(r_r_cy);
        n_ovx = 1'b1;
        n_ovy = 1'b1;
        if (n_fx > SAT_MAX) begin
            n_sx = SAT_MAX[31:0];
        end else if (n_fx < SAT_MIN) begin
            n_sx = SAT_MIN[31:0];
        end else begin
            n_sx  = n_fx[31:0];
            n_ovx = 1'b0;
        end
        if (n_fy > SAT_MAX) begin
            n_sy = SAT_MAX[31:0];
        end else if (n_fy < SAT_MIN) begin
            n_sy = SAT_MIN[31:0];
        end else begin
            n_sy  = n_fy[31:0];
            n_ovy = 1'b0;
        end
    end

    t_rot_out r_out;
    logic     r_out_v;

    always_ff @(posedge i_clk) begin
        r_out.rotated_x <= n_sx;
        r_out.rotated_y <= n_sy;
        r_out.overflow  <= n_ovx | n_ovy;
    end

    // valid bits for the back-end stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v   <= 1'b0;
            r_p_v   <= 1'b0;
            r_r_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_f_v   <= r_cv[STEPS];
            r_p_v   <= r_f_v;
            r_r_v   <= r_p_v;
            r_out_v <= r_r_v;
        end
    end

    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

`ifndef SYNTHESIS
    // every result strobe traces back to an earlier started transaction
    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching start");

    // a started transaction always produces its strobe unless reset intervenes
    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY (o_result_valid || !$past(i_rst_n, LATENCY - 1)))
        else $error("started transaction lost in the pipeline");

    // overflow only with a coordinate pinned at a rail
    a_overflow_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.overflow) |->
            (o_result.rotated_x == SAT_MAX[31:0] || o_result.rotated_x == SAT_MIN[31:0] ||
             o_result.rotated_y == SAT_MAX[31:0] || o_result.rotated_y == SAT_MIN[31:0]))
        else $error("overflow flagged without a saturated coordinate");
`endif

endmodule
